// File: hw/rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants for the tiled surface address block
// Register indexes, reset values and the structs that travel between stages.
// ----------------------------------------------------------------------------
package tsa_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIPE_MODE        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BANK_COUNT_LOG2  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BANK_WIDTH_LOG2  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BANK_HEIGHT_LOG2 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MT_WIDTH_LOG2    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MT_HEIGHT_LOG2   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MT_PER_ROW       = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIPE_INTERLEAVE  = 3'd7;

   // Reset values
   localparam logic       RST_PIPE_MODE        = 1'b0;
   localparam logic [2:0] RST_BANK_COUNT_LOG2  = 3'd4;
   localparam logic [1:0] RST_BANK_WIDTH_LOG2  = 2'd0;
   localparam logic [1:0] RST_BANK_HEIGHT_LOG2 = 2'd0;
   localparam logic [3:0] RST_MT_WIDTH_LOG2    = 4'd7;
   localparam logic [3:0] RST_MT_HEIGHT_LOG2   = 4'd6;
   localparam logic [9:0] RST_MT_PER_ROW       = 10'd15;
   localparam logic [3:0] RST_PIPE_INTERLEAVE  = 4'd8;

   // Legal ranges of the saturated fields
   localparam logic [2:0] BANK_LOG2_MIN = 3'd1;
   localparam logic [2:0] BANK_LOG2_MAX = 3'd4;
   localparam logic [3:0] MT_LOG2_MIN   = 4'd3;
   localparam logic [3:0] MT_LOG2_MAX   = 4'd10;

   // Micro-tile geometry: 8x8 elements of 4 bytes
   localparam int MICRO_DIM_LOG2 = 3;

   // Decoded configuration seen by every stage
   typedef struct packed {
      logic       pipe_mode;
      logic [2:0] pipe_bits;
      logic [2:0] bank_bits;
      logic [1:0] bank_width_log2;
      logic [1:0] bank_height_log2;
      logic [3:0] mt_width_log2;
      logic [3:0] mt_height_log2;
      logic [9:0] mt_per_row;
      logic [3:0] pipe_interleave_log2;
      logic [4:0] mt_shift;
   } cfg_type;

   // Small per-transaction fields produced by the swizzle stage
   typedef struct packed {
      logic [5:0] elem;
      logic [3:0] pipe;
      logic [3:0] bank;
      logic [5:0] tile;
   } swz_type;

   // Linear offset with the bits still to be spliced in
   typedef struct packed {
      logic [31:0] total;
      logic [3:0]  pipe;
      logic [3:0]  bank;
   } off_type;

endpackage

// File: hw/rtl/tsa_csr.sv
// ----------------------------------------------------------------------------
// tsa_csr: configuration registers
// Holds the written values and presents them saturated and decoded.
// ----------------------------------------------------------------------------
module tsa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tsa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tsa_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output tsa_pkg::cfg_type                    cfg
);
   import tsa_pkg::*;

   logic       pipe_mode_ff;
   logic [2:0] bank_count_log2_ff;
   logic [1:0] bank_width_log2_ff;
   logic [1:0] bank_height_log2_ff;
   logic [3:0] mt_width_log2_ff;
   logic [3:0] mt_height_log2_ff;
   logic [9:0] mt_per_row_ff;
   logic [3:0] pipe_interleave_ff;

   logic [2:0] bank_sat;
   logic [3:0] mtw_sat;
   logic [3:0] mth_sat;
   logic [2:0] pipe_bits;
   logic [5:0] shift_up;
   logic [5:0] shift_down;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_mode_ff        <= RST_PIPE_MODE;
         bank_count_log2_ff  <= RST_BANK_COUNT_LOG2;
         bank_width_log2_ff  <= RST_BANK_WIDTH_LOG2;
         bank_height_log2_ff <= RST_BANK_HEIGHT_LOG2;
         mt_width_log2_ff    <= RST_MT_WIDTH_LOG2;
         mt_height_log2_ff   <= RST_MT_HEIGHT_LOG2;
         mt_per_row_ff       <= RST_MT_PER_ROW;
         pipe_interleave_ff  <= RST_PIPE_INTERLEAVE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PIPE_MODE:        pipe_mode_ff        <= csr_write_data[0];
            CSR_BANK_COUNT_LOG2:  bank_count_log2_ff  <= csr_write_data[2:0];
            CSR_BANK_WIDTH_LOG2:  bank_width_log2_ff  <= csr_write_data[1:0];
            CSR_BANK_HEIGHT_LOG2: bank_height_log2_ff <= csr_write_data[1:0];
            CSR_MT_WIDTH_LOG2:    mt_width_log2_ff    <= csr_write_data[3:0];
            CSR_MT_HEIGHT_LOG2:   mt_height_log2_ff   <= csr_write_data[3:0];
            CSR_MT_PER_ROW:       mt_per_row_ff       <= csr_write_data[9:0];
            CSR_PIPE_INTERLEAVE:  pipe_interleave_ff  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      bank_sat = bank_count_log2_ff;
      if (bank_count_log2_ff < BANK_LOG2_MIN) bank_sat = BANK_LOG2_MIN;
      if (bank_count_log2_ff > BANK_LOG2_MAX) bank_sat = BANK_LOG2_MAX;
      mtw_sat = mt_width_log2_ff;
      if (mt_width_log2_ff < MT_LOG2_MIN) mtw_sat = MT_LOG2_MIN;
      if (mt_width_log2_ff > MT_LOG2_MAX) mtw_sat = MT_LOG2_MAX;
      mth_sat = mt_height_log2_ff;
      if (mt_height_log2_ff < MT_LOG2_MIN) mth_sat = MT_LOG2_MIN;
      if (mt_height_log2_ff > MT_LOG2_MAX) mth_sat = MT_LOG2_MAX;
      pipe_bits = pipe_mode_ff ? 3'd4 : 3'd3;
      // Macro-tile bytes exponent less the pipe and bank bits; never negative once saturated
      shift_up   = 6'(mtw_sat) + 6'(mth_sat) + 6'd2;
      shift_down = 6'(pipe_bits) + 6'(bank_sat);
   end

   always_comb begin
      cfg.pipe_mode            = pipe_mode_ff;
      cfg.pipe_bits            = pipe_bits;
      cfg.bank_bits            = bank_sat;
      cfg.bank_width_log2      = bank_width_log2_ff;
      cfg.bank_height_log2     = bank_height_log2_ff;
      cfg.mt_width_log2        = mtw_sat;
      cfg.mt_height_log2       = mth_sat;
      cfg.mt_per_row           = mt_per_row_ff;
      cfg.pipe_interleave_log2 = pipe_interleave_ff;
      cfg.mt_shift             = 5'(shift_up - shift_down);
   end

endmodule

// File: hw/rtl/tsa_swizzle.sv
// ----------------------------------------------------------------------------
// tsa_swizzle: first pipeline stage
// Micro-tile element index, pipe and bank XOR patterns, bank tile index
// and macro-tile coordinates.
// ----------------------------------------------------------------------------
module tsa_swizzle #(
   parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [COORD_BITS-1:0] coord_x,
   input  logic [COORD_BITS-1:0] coord_y,
   input  tsa_pkg::cfg_type      cfg,
   output tsa_pkg::swz_type      swz_ff,
   output logic [COORD_BITS-4:0] x_quot_ff,
   output logic [COORD_BITS-4:0] y_quot_ff
);
   import tsa_pkg::*;

   localparam int EXT_BITS = COORD_BITS + 14;

   logic [EXT_BITS-1:0]   x_ext;
   logic [EXT_BITS-1:0]   y_ext;
   logic [EXT_BITS-1:0]   x_bank;
   logic [EXT_BITS-1:0]   y_bank;
   logic [EXT_BITS-1:0]   x_col;
   logic [COORD_BITS-1:0] x_shift;
   logic [COORD_BITS-1:0] y_shift;
   logic [2:0]            col_mask;
   logic [2:0]            row_mask;
   logic [2:0]            t_col;
   logic [2:0]            t_row;
   swz_type               swz_in;

   always_comb begin
      x_ext  = EXT_BITS'(coord_x);
      y_ext  = EXT_BITS'(coord_y);
      x_bank = x_ext >> (4'(cfg.bank_width_log2) + 4'(cfg.pipe_bits));
      y_bank = y_ext >> cfg.bank_height_log2;
      x_col  = x_ext >> (4'(MICRO_DIM_LOG2) + 4'(cfg.pipe_bits));

      // Element order inside the micro-tile: x0 x1 y0 x2 y1 y2
      swz_in.elem = {coord_y[2], coord_y[1], coord_x[2],
                     coord_y[0], coord_x[1], coord_x[0]};

      swz_in.pipe[0] = coord_x[3] ^ coord_y[3] ^ coord_x[4];
      swz_in.pipe[1] = coord_x[4] ^ coord_y[4];
      swz_in.pipe[2] = coord_x[5] ^ coord_y[5];
      swz_in.pipe[3] = cfg.pipe_mode & (coord_x[6] ^ coord_y[5]);

      swz_in.bank = '0;
      case (cfg.bank_bits)
         3'd1: begin
            swz_in.bank[0] = x_bank[3] ^ y_bank[3];
         end
         3'd2: begin
            swz_in.bank[0] = x_bank[3] ^ y_bank[4];
            swz_in.bank[1] = x_bank[4] ^ y_bank[3];
         end
         3'd3: begin
            swz_in.bank[0] = x_bank[3] ^ y_bank[5];
            swz_in.bank[1] = x_bank[4] ^ y_bank[4] ^ y_bank[5];
            swz_in.bank[2] = x_bank[5] ^ y_bank[3];
         end
         default: begin
            swz_in.bank[0] = x_bank[3] ^ y_bank[6];
            swz_in.bank[1] = x_bank[4] ^ y_bank[5] ^ y_bank[6];
            swz_in.bank[2] = x_bank[5] ^ y_bank[4];
            swz_in.bank[3] = x_bank[6] ^ y_bank[3];
         end
      endcase

      // Bank interleave tile: row and column are disjoint fields
      col_mask    = 3'((4'd1 << cfg.bank_width_log2) - 4'd1);
      row_mask    = 3'((4'd1 << cfg.bank_height_log2) - 4'd1);
      t_col       = x_col[2:0] & col_mask;
      t_row       = coord_y[5:3] & row_mask;
      swz_in.tile = (6'(t_row) << cfg.bank_width_log2) | 6'(t_col);

      x_shift = coord_x >> cfg.mt_width_log2;
      y_shift = coord_y >> cfg.mt_height_log2;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         swz_ff    <= swz_in;
         x_quot_ff <= x_shift[COORD_BITS-4:0];
         y_quot_ff <= y_shift[COORD_BITS-4:0];
      end
   end

endmodule

// File: hw/rtl/tsa_offset.sv
// ----------------------------------------------------------------------------
// tsa_offset: second and third pipeline stages
// Macro-tile index by multiply-add, then scale and add the tile offset.
// ----------------------------------------------------------------------------
module tsa_offset #(
   parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  index_enable,
   input  logic                  total_enable,
   input  logic [COORD_BITS-4:0] x_quot,
   input  logic [COORD_BITS-4:0] y_quot,
   input  tsa_pkg::swz_type      swz,
   input  tsa_pkg::cfg_type      cfg,
   output tsa_pkg::off_type      off_ff
);
   import tsa_pkg::*;

   localparam int QUOT_BITS  = COORD_BITS - 3;
   localparam int PROD_BITS  = QUOT_BITS + 10;
   localparam int INDEX_BITS = PROD_BITS + 1;

   logic [PROD_BITS-1:0]  product;
   logic [INDEX_BITS-1:0] index_in;
   logic [INDEX_BITS-1:0] index_ff;
   swz_type               swz_ff;
   logic [63:0]           scaled;
   off_type               off_in;

   always_comb begin
      product  = PROD_BITS'(y_quot) * PROD_BITS'(cfg.mt_per_row);
      index_in = INDEX_BITS'(product) + INDEX_BITS'(x_quot);
   end

   always_ff @(posedge clock) begin
      if (index_enable) begin
         index_ff <= index_in;
         swz_ff   <= swz;
      end
   end

   // Tile and element offsets occupy disjoint bits: tile*256 + elem*4
   always_comb begin
      scaled       = 64'(index_ff) << cfg.mt_shift;
      off_in.total = scaled[31:0] + 32'({swz_ff.tile, swz_ff.elem, 2'b00});
      off_in.pipe  = swz_ff.pipe;
      off_in.bank  = swz_ff.bank;
   end

   always_ff @(posedge clock) begin
      if (total_enable) begin
         off_ff <= off_in;
      end
   end

endmodule

// File: hw/rtl/tsa_splice.sv
// ----------------------------------------------------------------------------
// tsa_splice: final pipeline stage
// Insert pipe and bank bits above the pipe interleave bits.
// ----------------------------------------------------------------------------
module tsa_splice (
   input  logic             clock,
   input  logic             enable,
   input  tsa_pkg::off_type off,
   input  tsa_pkg::cfg_type cfg,
   output logic [31:0]      byte_offset_ff
);
   import tsa_pkg::*;

   logic [4:0]  bank_pos;
   logic [4:0]  high_pos;
   logic [31:0] low_mask;
   logic [31:0] byte_offset_in;

   always_comb begin
      bank_pos = 5'(cfg.pipe_interleave_log2) + 5'(cfg.pipe_bits);
      high_pos = bank_pos + 5'(cfg.bank_bits);
      low_mask = (32'd1 << cfg.pipe_interleave_log2) - 32'd1;
      byte_offset_in = (off.total & low_mask)
                     | (32'(off.pipe) << cfg.pipe_interleave_log2)
                     | (32'(off.bank) << bank_pos)
                     | ((off.total >> cfg.pipe_interleave_log2) << high_pos);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         byte_offset_ff <= byte_offset_in;
      end
   end

endmodule

// File: hw/rtl/tiled_surface_address.sv
// ----------------------------------------------------------------------------
// tiled_surface_address: byte offset of a 32-bit element in a 2D-thin
// macro-tiled surface
// Swizzles (x, y) into a display micro-tile, adds pipe and bank XOR bits,
// forms the macro-tile and bank tile offset and splices the lot together.
// ----------------------------------------------------------------------------
//
//   Port group  Direction  Handshake              Carries
//   req_        in         req_valid / req_stall  coord_x, coord_y
//   rsp_        out        rsp_valid / rsp_stall  byte_offset
//   csr_        in         csr_write_enable       index, write data
//
// Four register stages: swizzle, macro-tile index multiply, scale and add,
// splice, in that order from acceptance to rsp_valid; one
// transaction is taken every cycle while rsp_stall is low.
// Each stage holds its own valid bit and advances when empty or when the
// stage after it advances, so bubbles close up under a stall and input is
// refused only once all four stages are full.
// Reset is synchronous, clears the valid bits and loads the configuration reset values.
// Write configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module tiled_surface_address #(
   parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [COORD_BITS-1:0]              req_coord_x,
   input  logic [COORD_BITS-1:0]              req_coord_y,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [31:0]                        rsp_byte_offset,
   // configuration
   input  logic                               csr_write_enable,
   input  logic [tsa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsa_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import tsa_pkg::*;

   cfg_type               cfg;
   swz_type               swz;
   off_type               off;
   logic [COORD_BITS-4:0] x_quot;
   logic [COORD_BITS-4:0] y_quot;

   // Valid bits travelling with the data
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_valid_ff;

   // Stage advance: load when empty or when the next stage moves on
   logic adv1;
   logic adv2;
   logic adv3;
   logic adv4;

   always_comb begin
      adv4      = !s4_valid_ff || !rsp_stall;
      adv3      = !s3_valid_ff || adv4;
      adv2      = !s2_valid_ff || adv3;
      adv1      = !s1_valid_ff || adv2;
      req_stall = !adv1;
      rsp_valid = s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Configuration registers, saturated and decoded for the stages
   tsa_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Stage 1: bit swizzles and macro-tile coordinates
   tsa_swizzle #(
      .COORD_BITS (COORD_BITS)
   ) u_swizzle (
      .clock     (clock),
      .enable    (adv1),
      .coord_x   (req_coord_x),
      .coord_y   (req_coord_y),
      .cfg       (cfg),
      .swz_ff    (swz),
      .x_quot_ff (x_quot),
      .y_quot_ff (y_quot)
   );

   // Stages 2 and 3: macro-tile index, then the linear offset
   tsa_offset #(
      .COORD_BITS (COORD_BITS)
   ) u_offset (
      .clock        (clock),
      .index_enable (adv2),
      .total_enable (adv3),
      .x_quot       (x_quot),
      .y_quot       (y_quot),
      .swz          (swz),
      .cfg          (cfg),
      .off_ff       (off)
   );

   // Stage 4: splice pipe and bank bits into the output register
   tsa_splice u_splice (
      .clock          (clock),
      .enable         (adv4),
      .off            (off),
      .cfg            (cfg),
      .byte_offset_ff (rsp_byte_offset)
   );

   // Input is refused only when every stage holds a transaction and the
   // response is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && rsp_stall))
      else $error("request refused with room in the pipeline");

   // An accepted request lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request lost at stage one");

   // A transaction in stage three moves into the output when it advances
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && adv4) |=> rsp_valid)
      else $error("transaction dropped between stage three and the output");

   // A blocked stage three keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !adv4) |=> s3_valid_ff)
      else $error("stalled transaction lost in stage three");

endmodule
